FILE: hdl/qaps_pkg.sv
// ----------------------------------------------------------------------------
// qaps_pkg
// Shared types and constants for the quote-aware pattern search core.
// ----------------------------------------------------------------------------
package qaps_pkg;

	// pattern and position sizing
	localparam int PATTERN_MAX = 8;
	localparam int POS_W       = 32;
	localparam int PAT_IDX_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
	localparam int PLEN_W      = 4;
	localparam int PAT_W       = 8 * PATTERN_MAX;
	localparam int CFG_W       = 64;
	localparam int OFFS_W      = 32;
	localparam int MPOS_W      = 32;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// special characters
	localparam logic [7:0] CHR_DQ  = 8'h22;
	localparam logic [7:0] CHR_SQ  = 8'h27;
	localparam logic [7:0] CHR_BSL = 8'h5C;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_PATTERN_BYTES  = 2'd0,
		REG_PATTERN_LENGTH = 2'd1,
		REG_START_OFFSET   = 2'd2
	} reg_index_t;

	// literal tracker modes
	typedef enum logic [1:0] {
		LIT_OUT = 2'd0,
		LIT_DQ  = 2'd1,
		LIT_SQ  = 2'd2
	} lit_mode_t;

	// one classified word on its way from front to back
	typedef struct packed {
		logic [7:0]       code_byte;
		logic             elig;
		logic             last;
		logic [POS_W-1:0] pos;
	} queue_word_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

FILE: hdl/qaps_front.sv
// ----------------------------------------------------------------------------
// qaps_front
// Accepts text bytes, tracks quoted literals and the byte position, and
// tags each byte with whether it may start a match.
// ----------------------------------------------------------------------------
module qaps_front import qaps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] code_byte
	input  logic                s_tlast,   // is_last
	input  logic [OFFS_W-1:0]   start_offset,
	input  queue_status_t       q_status,
	output logic                push,
	output queue_word_t         push_word
);

	lit_mode_t        mode_q, mode_d;
	logic [7:0]       prev_q, prev_d;
	logic [POS_W-1:0] idx_q, idx_d;
	logic             elig;
	logic             active;

	assign s_tready = !q_status.full;
	assign push     = s_tvalid && s_tready;
	assign active   = idx_q >= POS_W'(start_offset);

	// classify the incoming byte and work out the next tracker state
	always_comb begin
		mode_d = mode_q;
		prev_d = prev_q;
		elig   = 1'b0;
		if (active) begin
			unique case (mode_q)
				LIT_DQ: begin
					if (s_tdata == CHR_DQ && prev_q != CHR_BSL)
						mode_d = LIT_OUT;
				end
				LIT_SQ: begin
					if (s_tdata == CHR_SQ && prev_q != CHR_BSL)
						mode_d = LIT_OUT;
				end
				default: begin
					if (s_tdata == CHR_DQ)
						mode_d = LIT_DQ;
					else if (s_tdata == CHR_SQ)
						mode_d = LIT_SQ;
					else
						elig = 1'b1;
				end
			endcase
			prev_d = s_tdata;
		end
		// saturate the position
		idx_d = (idx_q == {POS_W{1'b1}}) ? idx_q : idx_q + POS_W'(1);
		// the last byte starts a fresh text
		if (s_tlast) begin
			mode_d = LIT_OUT;
			prev_d = 8'h00;
			idx_d  = '0;
		end
	end

	assign push_word = '{code_byte: s_tdata, elig: elig, last: s_tlast, pos: idx_q};

	// advance tracker state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= LIT_OUT;
			prev_q <= 8'h00;
			idx_q  <= '0;
		end else if (push) begin
			mode_q <= mode_d;
			prev_q <= prev_d;
			idx_q  <= idx_d;
		end
	end

endmodule

FILE: hdl/qaps_queue.sv
// ----------------------------------------------------------------------------
// qaps_queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module qaps_queue import qaps_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  queue_word_t   push_word,
	input  logic          pop,
	output queue_word_t   head_word,
	output queue_status_t status
);

	queue_word_t         mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign status.full  = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign status.empty = count_q == '0;
	assign head_word    = mem_q[rd_ptr_q];

	// store pushed words
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_word;
	end

	// move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			if (push && !pop)
				count_q <= count_q + (QUEUE_AW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QUEUE_AW+1)'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.full && !pop |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.empty |-> !pop)
		else $error("queue read while empty");

endmodule

FILE: hdl/qaps_back.sv
// ----------------------------------------------------------------------------
// qaps_back
// Shifts classified bytes into the match window, compares against the
// pattern and holds the single result word for the output side.
// ----------------------------------------------------------------------------
module qaps_back import qaps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [PAT_W-1:0]    pattern_bytes,
	input  logic [PLEN_W-1:0]   pattern_length,
	input  queue_status_t       q_status,
	input  queue_word_t         head_word,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [MPOS_W-1:0]   m_tdata,   // [31:0] match_position
	output logic                m_tuser    // found
);

	logic [7:0]           win_q  [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] elig_q;
	logic                 done_q;
	logic                 valid_q;
	logic                 found_q;
	logic [MPOS_W-1:0]    mpos_q;

	logic [7:0]           win_n  [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] elig_n;
	logic [LEN_W-1:0]     len;
	logic [PAT_IDX_W-1:0] len_m1;
	logic [PATTERN_MAX-1:0] byte_ok;
	logic                 hit;
	logic [POS_W-1:0]     hit_pos;
	logic                 res_load;

	// clamp the pattern length
	assign len    = (pattern_length > PLEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
	                                                        : LEN_W'(pattern_length);
	assign len_m1 = PAT_IDX_W'(len - LEN_W'(1));

	// window as it stands after this byte
	always_comb begin
		win_n[0]  = head_word.code_byte;
		elig_n[0] = head_word.elig;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win_n[k]  = win_q[k-1];
			elig_n[k] = elig_q[k-1];
		end
	end

	// compare each window byte with its pattern byte
	always_comb begin
		logic [PAT_IDX_W-1:0] pi;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			pi         = PAT_IDX_W'(len_m1 - PAT_IDX_W'(k));
			byte_ok[k] = (k >= int'(len)) ||
			             (win_n[k] == pattern_bytes[{pi, 3'b000} +: 8]);
		end
	end

	assign hit     = (len == '0) ? head_word.elig : (elig_n[len_m1] && (&byte_ok));
	assign hit_pos = (len == '0) ? head_word.pos : head_word.pos - POS_W'(len_m1);

	// take a word when the output register is free or draining
	assign pop      = !q_status.empty && (!valid_q || m_tready);
	assign res_load = pop && !done_q && (hit || head_word.last);

	// window, eligibility flags and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elig_q <= '0;
			done_q <= 1'b0;
			for (int k = 0; k < PATTERN_MAX; k++)
				win_q[k] <= 8'h00;
		end else if (pop) begin
			if (head_word.last) begin
				elig_q <= '0;
				done_q <= 1'b0;
				for (int k = 0; k < PATTERN_MAX; k++)
					win_q[k] <= 8'h00;
			end else begin
				elig_q <= elig_n;
				win_q  <= win_n;
				if (res_load)
					done_q <= 1'b1;
			end
		end
	end

	// output register: hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (res_load)
			valid_q <= 1'b1;
		else if (m_tready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			found_q <= hit;
			mpos_q  <= hit ? MPOS_W'(hit_pos) : '0;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = mpos_q;
	assign m_tuser  = found_q;

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !m_tready |-> !pop)
		else $error("queue drained while result stalled");

	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && !head_word.last |=> done_q)
		else $error("done flag not set after result");

	a_one_per_text: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head_word.last |=> !done_q && elig_q == '0)
		else $error("text state not cleared at last byte");

endmodule

FILE: hdl/quote_aware_pattern_search_core.sv
// ----------------------------------------------------------------------------
// quote_aware_pattern_search_core
// Finds the first match of a short pattern that starts outside quoted
// literals in a byte stream; one found/not-found result per text.
// ----------------------------------------------------------------------------
//  channel | direction | tdata            | tlast   | tuser
//  s_      | in        | [7:0] code_byte  | is_last | -
//  m_      | out       | [31:0] match_pos | -       | found
//  cfg_    | in        | cfg_wdata by cfg_index (0 pattern, 1 length, 2 offset)
//
// One byte per cycle sustained while the queue has room; the literal tracker in the front
// and the window compare in the back each take a word every cycle unless held by a full queue or a stalled result.
// A byte reaches the result through a queue entry and the output register.
// A four-word queue lets the front keep taking bytes while m_tready is low.
// Reset clears the configuration registers and all text state; no clear pass.
// ----------------------------------------------------------------------------
module quote_aware_pattern_search_core import qaps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] code_byte
	input  logic                s_tlast,   // is_last
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [MPOS_W-1:0]   m_tdata,   // [31:0] match_position
	output logic                m_tuser    // found
);

	logic [PAT_W-1:0]  pattern_q;
	logic [PLEN_W-1:0] plen_q;
	logic [OFFS_W-1:0] offset_q;

	logic              push;
	logic              pop;
	queue_word_t       push_word;
	queue_word_t       head_word;
	queue_status_t     q_status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= '0;
			offset_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PATTERN_BYTES:  pattern_q <= PAT_W'(cfg_wdata);
				REG_PATTERN_LENGTH: plen_q    <= cfg_wdata[PLEN_W-1:0];
				REG_START_OFFSET:   offset_q  <= cfg_wdata[OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	qaps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.start_offset (offset_q),
		.q_status     (q_status),
		.push         (push),
		.push_word    (push_word)
	);

	qaps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head_word (head_word),
		.status    (q_status)
	);

	qaps_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pattern_bytes  (pattern_q),
		.pattern_length (plen_q),
		.q_status       (q_status),
		.head_word      (head_word),
		.pop            (pop),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser)
	);

endmodule
